@@ sv/pitat_pkg.sv @@
// Shared constants for the point-in-triangle area test.
`timescale 1ns / 1ps
package pitat_pkg;
  localparam int FIELD_W        = 16;
  localparam int COORD_BITS_DEF = 16;
  localparam int TOL_W          = 16;
  localparam logic [TOL_W-1:0] TOL_RESET = 16'd4;
endpackage

@@ sv/pitat_in_if.sv @@
// Query channel: point and three vertices.
`timescale 1ns / 1ps
interface pitat_in_if import pitat_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [FIELD_W-1:0] query_x, query_y, query_z;
  logic signed [FIELD_W-1:0] vert0_x, vert0_y, vert0_z;
  logic signed [FIELD_W-1:0] vert1_x, vert1_y, vert1_z;
  logic signed [FIELD_W-1:0] vert2_x, vert2_y, vert2_z;
  modport source (output valid, query_x, query_y, query_z, vert0_x, vert0_y, vert0_z,
                  vert1_x, vert1_y, vert1_z, vert2_x, vert2_y, vert2_z, input ready);
  modport sink (input valid, query_x, query_y, query_z, vert0_x, vert0_y, vert0_z,
                vert1_x, vert1_y, vert1_z, vert2_x, vert2_y, vert2_z, output ready);
endinterface

@@ sv/pitat_out_if.sv @@
// Result channel: inside flag.
`timescale 1ns / 1ps
interface pitat_out_if;
  logic valid;
  logic ready;
  logic inside_res;
  modport source (output valid, inside_res, input ready);
  modport sink (input valid, inside_res, output ready);
endinterface

@@ sv/pitat_cfg_if.sv @@
// Configuration write channel: tolerance register.
`timescale 1ns / 1ps
interface pitat_cfg_if import pitat_pkg::*; ();
  logic valid;
  logic ready;
  logic [TOL_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

@@ sv/pitat_area.sv @@
// Pipelined doubled area of a triangle from its edge vectors e1_i and e2_i.
`timescale 1ns / 1ps
module pitat_area import pitat_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int EW = COORD_BITS + 1,
  localparam int PW = 2 * EW,
  localparam int MW = 2 * COORD_BITS + 1,
  localparam int H  = (MW + 1) / 2,
  localparam int HH = MW - H,
  localparam int R  = 2 * COORD_BITS + 2,
  localparam int N  = 2 * R,
  localparam int ST = 5 + R
) (
  input  logic                 clk_i,
  input  logic [ST-1:0]        ld_i,
  input  logic signed [EW-1:0] e1_i [3],
  input  logic signed [EW-1:0] e2_i [3],
  output logic [R-1:0]         area_o
);
  logic signed [PW-1:0] prod_q [6];
  logic [MW-1:0] mag_q [3];
  logic [2*HH-1:0] hh_q [3];
  logic [HH+H-1:0] hl_q [3];
  logic [2*H-1:0]  ll_q [3];
  logic [2*MW-1:0] sq_q [3];
  logic [N-1:0]    sum_q;
  logic [R+1:0]    rem_q  [R];
  logic [R-1:0]    root_q [R];
  logic [N-1:0]    n_q    [R];

  // products of the cross terms
  always_ff @(posedge clk_i) begin
    if (ld_i[0]) begin
      prod_q[0] <= PW'(e1_i[1] * e2_i[2]);
      prod_q[1] <= PW'(e1_i[2] * e2_i[1]);
      prod_q[2] <= PW'(e1_i[2] * e2_i[0]);
      prod_q[3] <= PW'(e1_i[0] * e2_i[2]);
      prod_q[4] <= PW'(e1_i[0] * e2_i[1]);
      prod_q[5] <= PW'(e1_i[1] * e2_i[0]);
    end
  end

  // cross components, magnitude
  always_ff @(posedge clk_i) begin
    if (ld_i[1]) begin
      for (int k = 0; k < 3; k++) begin
        logic signed [PW:0] c;
        c = (PW+1)'(prod_q[2*k]) - (PW+1)'(prod_q[2*k+1]);
        mag_q[k] <= c[PW] ? MW'(-c) : MW'(c);
      end
    end
  end

  // split squares into partial products
  always_ff @(posedge clk_i) begin
    if (ld_i[2]) begin
      for (int k = 0; k < 3; k++) begin
        hh_q[k] <= mag_q[k][MW-1:H] * mag_q[k][MW-1:H];
        hl_q[k] <= mag_q[k][MW-1:H] * mag_q[k][H-1:0];
        ll_q[k] <= mag_q[k][H-1:0] * mag_q[k][H-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i[3]) begin
      for (int k = 0; k < 3; k++) begin
        sq_q[k] <= ((2*MW)'(hh_q[k]) << (2*H)) + ((2*MW)'(hl_q[k]) << (H+1))
                 + (2*MW)'(ll_q[k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i[4]) begin
      sum_q <= N'(sq_q[0]) + N'(sq_q[1]) + N'(sq_q[2]);
    end
  end

  // restoring square root, one root bit per stage
  for (genvar j = 0; j < R; j++) begin : g_sqrt
    logic [R+1:0] rem_in, rem_sh, trial;
    logic [R-1:0] root_in;
    logic [N-1:0] n_in;
    if (j == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign n_in    = sum_q;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
      assign n_in    = n_q[j-1];
    end
    assign rem_sh = {rem_in[R-1:0], n_in[N-1:N-2]};
    assign trial  = {root_in, 2'b01};
    always_ff @(posedge clk_i) begin
      if (ld_i[5+j]) begin
        n_q[j] <= n_in << 2;
        if (rem_sh >= trial) begin
          rem_q[j]  <= rem_sh - trial;
          root_q[j] <= {root_in[R-2:0], 1'b1};
        end else begin
          rem_q[j]  <= rem_sh;
          root_q[j] <= {root_in[R-2:0], 1'b0};
        end
      end
    end
  end

  assign area_o = root_q[R-1];
endmodule

@@ sv/point_in_triangle_area_test.sv @@
// Top level: 3D point-in-triangle test by the sum of sub-triangle areas.
`timescale 1ns / 1ps
// Streaming test of whether a query point lies in a 3D triangle. Each beat on in_i carries
// P and vertices A, B, C; the block forms doubled areas floor(sqrt(|cross|^2)) of ABC, PAB,
// PBC, PCA and flags inside when |PAB+PBC+PCA-ABC| < area_tolerance, strictly. One query is
// accepted per cycle unless output back-pressure stalls the pipe; the stages are an edge
// stage, five multiply/sum stages, one square-root stage per root bit and an output stage.
// Every stage holds its own valid bit, so bubbles collapse under back-pressure. cfg_i is
// always ready; write it only while no query is in flight.
module point_in_triangle_area_test import pitat_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  pitat_in_if.sink    in_i,
  pitat_cfg_if.sink   cfg_i,
  pitat_out_if.source out_o
);
  localparam int EW = COORD_BITS + 1;
  localparam int R  = 2 * COORD_BITS + 2;
  localparam int ST = 5 + R;
  localparam int NS = ST + 2;

  logic [TOL_W-1:0] tol_q;
  logic [NS-1:0]    v_q, v_d;
  logic [NS:0]      rdy;
  logic signed [EW-1:0] pt [4][3];
  logic signed [EW-1:0] e1_q [4][3];
  logic signed [EW-1:0] e2_q [4][3];
  logic [R-1:0] area [4];
  logic         inside_q, inside_d;

  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
    end else if (cfg_i.valid) begin
      tol_q <= cfg_i.data;
    end
  end

  // a stage takes a beat when empty or when its beat moves on
  always_comb begin
    rdy[NS] = out_o.ready;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
    v_d[0] = rdy[0] ? in_i.valid : v_q[0];
    for (int k = 1; k < NS; k++) begin
      v_d[k] = rdy[k] ? v_q[k-1] : v_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_i.ready = rdy[0];

  // low COORD_BITS of each field, sign-extended; 0=P 1=A 2=B 3=C
  always_comb begin
    pt[0][0] = EW'($signed(in_i.query_x[COORD_BITS-1:0]));
    pt[0][1] = EW'($signed(in_i.query_y[COORD_BITS-1:0]));
    pt[0][2] = EW'($signed(in_i.query_z[COORD_BITS-1:0]));
    pt[1][0] = EW'($signed(in_i.vert0_x[COORD_BITS-1:0]));
    pt[1][1] = EW'($signed(in_i.vert0_y[COORD_BITS-1:0]));
    pt[1][2] = EW'($signed(in_i.vert0_z[COORD_BITS-1:0]));
    pt[2][0] = EW'($signed(in_i.vert1_x[COORD_BITS-1:0]));
    pt[2][1] = EW'($signed(in_i.vert1_y[COORD_BITS-1:0]));
    pt[2][2] = EW'($signed(in_i.vert1_z[COORD_BITS-1:0]));
    pt[3][0] = EW'($signed(in_i.vert2_x[COORD_BITS-1:0]));
    pt[3][1] = EW'($signed(in_i.vert2_y[COORD_BITS-1:0]));
    pt[3][2] = EW'($signed(in_i.vert2_z[COORD_BITS-1:0]));
  end

  // edges from first corner: ABC, PAB, PBC, PCA
  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      for (int k = 0; k < 3; k++) begin
        e1_q[0][k] <= pt[2][k] - pt[1][k];
        e2_q[0][k] <= pt[3][k] - pt[1][k];
        e1_q[1][k] <= pt[1][k] - pt[0][k];
        e2_q[1][k] <= pt[2][k] - pt[0][k];
        e1_q[2][k] <= pt[2][k] - pt[0][k];
        e2_q[2][k] <= pt[3][k] - pt[0][k];
        e1_q[3][k] <= pt[3][k] - pt[0][k];
        e2_q[3][k] <= pt[1][k] - pt[0][k];
      end
    end
  end

  for (genvar t = 0; t < 4; t++) begin : g_area
    pitat_area #(.COORD_BITS(COORD_BITS)) u_area (
      .clk_i  (clk_i),
      .ld_i   (rdy[NS-2:1]),
      .e1_i   (e1_q[t]),
      .e2_i   (e2_q[t]),
      .area_o (area[t])
    );
  end

  // final compare against tolerance
  always_comb begin
    logic [R+1:0] sum, tri_area, diff;
    sum      = (R+2)'(area[1]) + (R+2)'(area[2]) + (R+2)'(area[3]);
    tri_area = (R+2)'(area[0]);
    diff     = (sum >= tri_area) ? sum - tri_area : tri_area - sum;
    inside_d = diff < (R+2)'(tol_q);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[NS-1]) begin
      inside_q <= inside_d;
    end
  end

  assign out_o.valid      = v_q[NS-1];
  assign out_o.inside_res = inside_q;

  // input stalls only under output back-pressure
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (out_o.valid && !out_o.ready))
    else $error("input stalled without output back-pressure");

  a_zero_tol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && tol_q == '0) |-> !out_o.inside_res)
    else $error("inside reported with zero tolerance");

  a_accept_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> v_q[0])
    else $error("accepted beat not captured");
endmodule
